// ===== design/hms_up_down_timer_core_assert.svh =====
// ----------------------------------------------------------------------------
// hms_up_down_timer_core assertion macros
// Shared property forms for the timer core checks.
// ----------------------------------------------------------------------------
`ifndef HMS_UP_DOWN_TIMER_CORE_ASSERT_SVH
`define HMS_UP_DOWN_TIMER_CORE_ASSERT_SVH

// same-cycle implication
`define HUDT_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hudt check failed");

// next-cycle implication
`define HUDT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hudt check failed");

`endif

// ===== design/hudt_pkg.sv =====
// ----------------------------------------------------------------------------
// hudt_pkg
// Types, request codes and digit helpers for the hours:minutes:seconds timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hudt_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_STOP  = 2'd3;

  localparam logic [6:0] HOUR_MAX = 7'd99;
  localparam logic [5:0] MS_MAX   = 6'd59;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } req_t;

  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       running;
    logic       done;
  } disp_t;

  typedef struct packed {
    logic running;
    logic done;
  } flags_t;

  // tens digit of a value below 100 by reciprocal multiply
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v);
    logic [6:0] t;
    t = 7'(tens_of(v)) * 7'd10;
    return 4'(v - t);
  endfunction

endpackage

// ===== design/hudt_in_stage.sv =====
// ----------------------------------------------------------------------------
// hudt_in_stage
// Input register: captures one request item per cycle while s_tready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hudt_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [1:0]     s_tuser,
  input  logic [23:0]    s_tdata,
  input  logic           adv,
  output logic           vld,
  output hudt_pkg::req_t req
);
  import hudt_pkg::*;

  assign s_tready = !vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_tready) begin
      vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.req_type    <= s_tuser;
      req.load_hour   <= s_tdata[6:0];
      req.load_minute <= s_tdata[12:7];
      req.load_second <= s_tdata[18:13];
    end
  end

endmodule

// ===== design/hudt_timer_state.sv =====
// ----------------------------------------------------------------------------
// hudt_timer_state
// Up and down counters, run and done flags, and their per-item update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hudt_timer_state (
  input  logic              clk,
  input  logic              rst,
  input  logic              count_down,
  input  logic              en,
  input  hudt_pkg::req_t    req,
  output hudt_pkg::disp_t   disp_next,
  output hudt_pkg::flags_t  flags
);
  import hudt_pkg::*;

  logic [6:0] up_hours, up_hours_next, down_hours, down_hours_next;
  logic [5:0] up_minutes, up_minutes_next, down_minutes, down_minutes_next;
  logic [5:0] up_seconds, up_seconds_next, down_seconds, down_seconds_next;
  logic       run_enable, run_enable_next, done_flag, done_flag_next;
  logic       down_zero;

  assign down_zero = (down_hours == 7'd0) && (down_minutes == 6'd0) &&
                     (down_seconds == 6'd0);

  always_comb begin
    up_hours_next     = up_hours;
    up_minutes_next   = up_minutes;
    up_seconds_next   = up_seconds;
    down_hours_next   = down_hours;
    down_minutes_next = down_minutes;
    down_seconds_next = down_seconds;
    run_enable_next   = run_enable;
    done_flag_next    = done_flag;
    case (req.req_type)
      REQ_TICK: begin
        if (run_enable) begin
          if (count_down) begin
            if (down_zero) begin
              run_enable_next = 1'b0;
              done_flag_next  = 1'b1;
            end else begin
              done_flag_next = 1'b0;
              if (down_seconds == 6'd0) begin
                down_seconds_next = MS_MAX;
                if (down_minutes == 6'd0) begin
                  down_minutes_next = MS_MAX;
                  down_hours_next   = down_hours - 7'd1;
                end else begin
                  down_minutes_next = down_minutes - 6'd1;
                end
              end else begin
                down_seconds_next = down_seconds - 6'd1;
              end
            end
          end else begin
            if (up_seconds >= MS_MAX) begin
              up_seconds_next = 6'd0;
              if (up_minutes >= MS_MAX) begin
                up_minutes_next = 6'd0;
                up_hours_next   = (up_hours >= HOUR_MAX) ? 7'd0 : up_hours + 7'd1;
              end else begin
                up_minutes_next = up_minutes + 6'd1;
              end
            end else begin
              up_seconds_next = up_seconds + 6'd1;
            end
          end
        end
      end
      REQ_LOAD: begin
        if (count_down) begin
          down_hours_next   = (req.load_hour > HOUR_MAX) ? HOUR_MAX : req.load_hour;
          down_minutes_next = (req.load_minute > MS_MAX) ? MS_MAX : req.load_minute;
          down_seconds_next = (req.load_second > MS_MAX) ? MS_MAX : req.load_second;
        end
      end
      REQ_START: run_enable_next = 1'b1;
      default:   run_enable_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_hours     <= 7'd0;
      up_minutes   <= 6'd0;
      up_seconds   <= 6'd0;
      down_hours   <= 7'd0;
      down_minutes <= 6'd0;
      down_seconds <= 6'd0;
      run_enable   <= 1'b0;
      done_flag    <= 1'b0;
    end else if (en) begin
      up_hours     <= up_hours_next;
      up_minutes   <= up_minutes_next;
      up_seconds   <= up_seconds_next;
      down_hours   <= down_hours_next;
      down_minutes <= down_minutes_next;
      down_seconds <= down_seconds_next;
      run_enable   <= run_enable_next;
      done_flag    <= done_flag_next;
    end
  end

  assign disp_next.hours   = count_down ? down_hours_next : up_hours_next;
  assign disp_next.minutes = count_down ? down_minutes_next : up_minutes_next;
  assign disp_next.seconds = count_down ? down_seconds_next : up_seconds_next;
  assign disp_next.running = run_enable_next;
  assign disp_next.done    = done_flag_next;

  assign flags.running = run_enable;
  assign flags.done    = done_flag;

endmodule

// ===== design/hudt_out_stage.sv =====
// ----------------------------------------------------------------------------
// hudt_out_stage
// Result register: splits the selected counter into decimal digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hudt_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  output logic            rdy,
  input  hudt_pkg::disp_t disp,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [23:0]     m_tdata
);
  import hudt_pkg::*;

  logic [23:0] data_next;

  assign rdy = !m_tvalid || m_tready;

  always_comb begin
    data_next[3:0]   = tens_of(disp.hours);
    data_next[7:4]   = ones_of(disp.hours);
    data_next[10:8]  = 3'(tens_of({1'b0, disp.minutes}));
    data_next[14:11] = ones_of({1'b0, disp.minutes});
    data_next[17:15] = 3'(tens_of({1'b0, disp.seconds}));
    data_next[21:18] = ones_of({1'b0, disp.seconds});
    data_next[22]    = disp.running;
    data_next[23]    = disp.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy) begin
      m_tvalid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_vld) begin
      m_tdata <= data_next;
    end
  end

endmodule

// ===== design/hms_up_down_timer_core.sv =====
// ----------------------------------------------------------------------------
// hms_up_down_timer_core
// Hours:minutes:seconds stopwatch / countdown timer with a direction register.
// ----------------------------------------------------------------------------
// channel  dir  tuser           tdata (lowest bit up)
// s_*      in   req_type[1:0]   load_hour[6:0] load_minute[12:7] load_second[18:13]
// m_*      out  -               digits, is_running[22], countdown_done[23]
// cfg_*    in   -               cfg_wdata = count_down
//
// One item per cycle while m_tready stays high; each accepted item passes
// through the input register, then the state update into the result register.
// rst is synchronous: counters and flags clear, count_down returns to 0.
// m_tready low holds the result and, once the input register is full,
// drops s_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hms_up_down_timer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // req_type
  input  logic [23:0] s_tdata,   // load_hour, load_minute, load_second
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // hour_tens, hour_ones, minute_tens, minute_ones,
                                 // second_tens, second_ones, is_running,
                                 // countdown_done
);
  import hudt_pkg::*;

  logic   count_down;
  logic   in_vld;
  logic   out_rdy;
  logic   upd_en;
  req_t   req;
  disp_t  disp_next;
  flags_t flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_down <= 1'b0;
    end else if (cfg_we) begin
      count_down <= cfg_wdata;
    end
  end

  assign upd_en = in_vld && out_rdy;

  hudt_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .adv      (out_rdy),
    .vld      (in_vld),
    .req      (req)
  );

  hudt_timer_state u_state (
    .clk        (clk),
    .rst        (rst),
    .count_down (count_down),
    .en         (upd_en),
    .req        (req),
    .disp_next  (disp_next),
    .flags      (flags)
  );

  hudt_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (in_vld),
    .rdy      (out_rdy),
    .disp     (disp_next),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`include "hms_up_down_timer_core_assert.svh"

  `HUDT_ASSERT_NEXT(a_in_fill, clk, rst, s_tvalid && s_tready, in_vld)
  `HUDT_ASSERT_NEXT(a_out_fill, clk, rst, upd_en, m_tvalid)
  `HUDT_ASSERT_NOW(a_done_stops, clk, rst, $rose(flags.done), !flags.running)
  `HUDT_ASSERT_NOW(a_digits, clk, rst, m_tvalid,
    (m_tdata[3:0] <= 4'd9) && (m_tdata[7:4] <= 4'd9) && (m_tdata[10:8] <= 3'd5) &&
    (m_tdata[14:11] <= 4'd9) && (m_tdata[17:15] <= 3'd5) && (m_tdata[21:18] <= 4'd9))

endmodule

// ===== tb/tb_hms_up_down_timer_core.sv =====
// ----------------------------------------------------------------------------
// tb_hms_up_down_timer_core
// Self-checking bench for the hours:minutes:seconds up/down timer core.
// A predictor tracks both counters, the run and done flags and the direction
// register. Every accepted request yields one expected display word, which is
// compared field by field with the core's results. The run has three parts.
// A directed part covers stopped ticks, loads that are ignored or saturated,
// borrows, the countdown reaching zero and direction changes. An up-counter
// sweep at full rate crosses many minute carries. Random phases then mix the
// direction, the idling on both sides and a long result back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hms_up_down_timer_core;
  import hudt_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int RANDOM_PHASES   = 6;
  localparam int SWEEP_TICKS     = 700;
  localparam int MAX_PRINTED     = 100;

  class hms_display_predictor;
    bit       dir_down;
    bit [6:0] up_h, dn_h;
    bit [5:0] up_m, up_s, dn_m, dn_s;
    bit       running, done;
    logic [OUT_DATA_W-1:0] expected_displays[$];
    int mismatches;
    int checked;

    task report(string what, int got, int want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("[%0t] result %0d: %s got %0d expected %0d", $time, checked, what, got, want);
    endtask

    function void note_request(logic [1:0] req, logic [6:0] h, logic [5:0] m, logic [5:0] s);
      int hv, mv, sv;
      case (req)
        REQ_TICK: begin
          if (running && !dir_down) begin
            up_s++;
            if (up_s == 60) begin
              up_s = 0;
              up_m++;
              if (up_m == 60) begin
                up_m = 0;
                if (up_h == HOUR_MAX) up_h = 0;
                else up_h++;
              end
            end
          end else if (running) begin
            if (dn_h == 0 && dn_m == 0 && dn_s == 0) begin
              running = 0;
              done = 1;
            end else begin
              done = 0;
              if (dn_s != 0) begin
                dn_s--;
              end else begin
                dn_s = MS_MAX;
                if (dn_m != 0) begin
                  dn_m--;
                end else begin
                  dn_m = MS_MAX;
                  dn_h--;
                end
              end
            end
          end
        end
        REQ_LOAD: begin
          if (dir_down) begin
            dn_h = (h > HOUR_MAX) ? HOUR_MAX : h;
            dn_m = (m > MS_MAX) ? MS_MAX : m;
            dn_s = (s > MS_MAX) ? MS_MAX : s;
          end
        end
        REQ_START: running = 1;
        REQ_STOP:  running = 0;
      endcase
      hv = dir_down ? dn_h : up_h;
      mv = dir_down ? dn_m : up_m;
      sv = dir_down ? dn_s : up_s;
      expected_displays.push_back({done, running, 4'(sv % 10), 3'(sv / 10),
                                   4'(mv % 10), 3'(mv / 10), 4'(hv % 10), 4'(hv / 10)});
    endfunction

    task check_display(logic [OUT_DATA_W-1:0] got);
      logic [OUT_DATA_W-1:0] want;
      if (expected_displays.size() == 0) begin
        report("result with nothing pending, word", got, 0);
      end else begin
        want = expected_displays.pop_front();
        if (got[3:0]   !== want[3:0])   report("hour_tens", got[3:0], want[3:0]);
        if (got[7:4]   !== want[7:4])   report("hour_ones", got[7:4], want[7:4]);
        if (got[10:8]  !== want[10:8])  report("minute_tens", got[10:8], want[10:8]);
        if (got[14:11] !== want[14:11]) report("minute_ones", got[14:11], want[14:11]);
        if (got[17:15] !== want[17:15]) report("second_tens", got[17:15], want[17:15]);
        if (got[21:18] !== want[21:18]) report("second_ones", got[21:18], want[21:18]);
        if (got[22]    !== want[22])    report("is_running", got[22], want[22]);
        if (got[23]    !== want[23])    report("countdown_done", got[23], want[23]);
      end
      checked++;
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic                  cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [1:0]            s_tuser;   // req_type
  logic [IN_DATA_W-1:0]  s_tdata;   // load_hour, load_minute, load_second
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // hour_tens, hour_ones, minute_tens, minute_ones,
                                    // second_tens, second_ones, is_running,
                                    // countdown_done

  hms_display_predictor predictor = new();
  bit idling_on;
  bit hold_off_req;
  int items_sent;
  int direction_writes;
  int req_count [4];

  hms_up_down_timer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input logic [1:0] req, input logic [6:0] h,
                              input logic [5:0] m, input logic [5:0] s);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {5'd0, s, m, h};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predictor.note_request(req, h, m, s);
    req_count[req]++;
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_noise(input logic [1:0] req);
    send_request(req, 7'($urandom), 6'($urandom), 6'($urandom));
  endtask

  // hold the sender until every pending display has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (predictor.expected_displays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_direction(input bit down);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= down;
    @(posedge clk);
    cfg_we <= 1'b0;
    predictor.dir_down = down;
    direction_writes++;
  endtask

  initial begin : receiver
    int stall;
    m_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) predictor.check_display(m_tdata);
      if (hold_off_req) begin
        hold_off_req = 0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("** hms_up_down_timer_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int target;
    logic [5:0] m, s;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    s_tvalid  = 1'b0;
    s_tuser   = REQ_TICK;
    s_tdata   = '0;
    idling_on = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_direction(1'b0);
    send_request(REQ_TICK, 7'd0, 6'd0, 6'd0);
    send_request(REQ_LOAD, 7'd127, 6'd63, 6'd63);
    send_request(REQ_START, 7'd0, 6'd0, 6'd0);
    send_request(REQ_TICK, 7'd127, 6'd63, 6'd63);
    send_request(REQ_TICK, 7'd0, 6'd0, 6'd0);
    send_request(REQ_STOP, 7'd127, 6'd63, 6'd63);
    send_request(REQ_TICK, 7'd0, 6'd0, 6'd0);
    set_direction(1'b1);
    send_request(REQ_LOAD, 7'd127, 6'd63, 6'd63);
    send_request(REQ_LOAD, 7'd0, 6'd0, 6'd1);
    send_request(REQ_START, 7'd0, 6'd0, 6'd0);
    send_request(REQ_TICK, 7'd0, 6'd0, 6'd0);
    send_request(REQ_TICK, 7'd0, 6'd0, 6'd0);
    send_request(REQ_TICK, 7'd0, 6'd0, 6'd0);
    send_request(REQ_LOAD, 7'd1, 6'd0, 6'd0);
    send_request(REQ_START, 7'd0, 6'd0, 6'd0);
    send_request(REQ_TICK, 7'd0, 6'd0, 6'd0);
    send_request(REQ_LOAD, 7'd99, 6'd59, 6'd59);
    send_request(REQ_TICK, 7'd0, 6'd0, 6'd0);
    send_request(REQ_LOAD, 7'd0, 6'd0, 6'd0);
    send_request(REQ_TICK, 7'd0, 6'd0, 6'd0);
    send_request(REQ_STOP, 7'd0, 6'd0, 6'd0);
    set_direction(1'b0);
    send_request(REQ_TICK, 7'd0, 6'd0, 6'd0);

    // sweep the up counter through minute carries at full rate
    idling_on = 1'b0;
    send_noise(REQ_START);
    repeat (SWEEP_TICKS) send_noise(REQ_TICK);
    send_noise(REQ_STOP);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_direction((p < 2) ? p[0] : 1'($urandom));
      idling_on = (p % 3 != 2);
      if (p == 3) begin
        idling_on = 1'b0;
        hold_off_req = 1'b1;
      end
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if (predictor.dir_down && $urandom_range(0, 3) == 0) begin
          m = 6'($urandom_range(0, 1));
          s = 6'($urandom_range(0, 59));
          send_request(REQ_LOAD, 7'd0, m, s);
          send_noise(REQ_START);
          repeat (int'(m) * 60 + int'(s) + $urandom_range(1, 3)) send_noise(REQ_TICK);
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:64]:  send_noise(REQ_TICK);
            [65:79]: begin
              if ($urandom_range(0, 3) != 0)
                send_request(REQ_LOAD, 7'd0, 6'($urandom_range(0, 1)),
                             6'($urandom_range(0, 8)));
              else
                send_noise(REQ_LOAD);
            end
            [80:91]: send_noise(REQ_START);
            default: send_noise(REQ_STOP);
          endcase
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests: %0d ticks, %0d loads, %0d starts, %0d stops;",
             items_sent, req_count[REQ_TICK], req_count[REQ_LOAD], req_count[REQ_START],
             req_count[REQ_STOP]);
    $display("%0d results checked, %0d direction writes, a %0d-tick up sweep, a %0d-cycle hold-off.",
             predictor.checked, direction_writes, SWEEP_TICKS, HOLD_OFF_CYCLES);
    if (predictor.mismatches == 0) begin
      $display("** hms_up_down_timer_core: PASSED **");
    end else begin
      $display("%0d mismatches", predictor.mismatches);
      $display("** hms_up_down_timer_core: FAILED **");
    end
    $finish;
  end

endmodule
